// ----- sv/smd_pkg.sv -----
package smd_pkg;

	// field widths of the two channels
	localparam int DATA_W   = 8;
	localparam int PLEN_W   = 16;
	localparam int KIND_W   = 2;
	localparam int SIDX_W   = 2;
	localparam int OFF_W    = 24;
	localparam int TYPE_W   = 32;

	// internal widths
	localparam int WORD_W   = 32;           // length word from the header, in 8-byte units
	localparam int BR_W     = WORD_W + 3;   // byte counter within a segment
	localparam int CNT_W    = 4;            // header byte position
	localparam int HLEN_W   = CNT_W + 1;    // header length, up to 16
	localparam int NSEG_W   = 2;            // segment count register

	localparam logic [NSEG_W-1:0] NSEG_RESET     = 2'd3;
	localparam logic [PLEN_W-1:0] MIN_PACKET_LEN = 16'd8;

	// byte kind codes
	localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

endpackage

// ----- sv/smd_in_if.sv -----
interface smd_in_if import smd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              first_of_packet;
	logic [PLEN_W-1:0] packet_length;

	modport source (output valid, data_byte, first_of_packet, packet_length, input ready);
	modport sink   (input valid, data_byte, first_of_packet, packet_length, output ready);
endinterface

// ----- sv/smd_out_if.sv -----
interface smd_out_if import smd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] byte_kind;
	logic [SIDX_W-1:0] segment_index;
	logic [OFF_W-1:0]  segment_offset;
	logic [DATA_W-1:0] data_out;
	logic              message_done;
	logic [TYPE_W-1:0] message_type;

	modport source (output valid, byte_kind, segment_index, segment_offset, data_out,
		message_done, message_type, input ready);
	modport sink   (input valid, byte_kind, segment_index, segment_offset, data_out,
		message_done, message_type, output ready);
endinterface

// ----- sv/segmented_message_deframer.sv -----
// Segmented message deframer.
// ingress carries packet payload bytes, one beat per byte, with a first-of-packet
// mark and the packet length (sampled on the first beat). egress returns one beat
// per ingress beat: the byte's kind (ignored, header, segment data, over capacity),
// its segment index and offset, the byte itself, a message-done flag and the
// message type word. cfg_wr_en/cfg_wr_data set the segment count per message;
// write it only while no beat is in flight.
// The result of a byte appears on egress in the cycle after it is accepted.
// Throughput: one byte per cycle while egress is not stalled; the whole byte decision (header lane write,
// segment length compare, search for the next non-empty segment) is done in the
// accept cycle and lands in the egress register together with the state update.
// When egress stalls, the registered result holds and ingress.ready drops in the
// same cycle; ingress resumes the cycle the result is taken.
// Reset puts the block in header mode with all segment lengths, counters and the
// type word cleared, the segment count at 3 and egress empty.
module segmented_message_deframer import smd_pkg::*; #(
	parameter int MAX_SEGMENTS          = 3,
	parameter int SEGMENT_CAPACITY_LOG2 = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [NSEG_W-1:0] cfg_wr_data,
	smd_in_if.sink            ingress,
	smd_out_if.source         egress
);

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// configuration and state
	logic [NSEG_W-1:0] nseg_q;
	logic              hdr_mode_q;
	logic [CNT_W-1:0]  hdr_cnt_q;
	logic [TYPE_W-1:0] type_q;
	logic [WORD_W-1:0] len_q [MAX_SEGMENTS];
	logic [SEG_W-1:0]  cur_q;
	logic [BR_W-1:0]   br_q;
	logic              drop_q;

	// result register
	logic              res_valid_q;
	logic [KIND_W-1:0] res_kind_q;
	logic [SIDX_W-1:0] res_sidx_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [DATA_W-1:0] res_data_q;
	logic              res_done_q;
	logic [TYPE_W-1:0] res_type_q;

	// next values
	logic              accept;
	logic [NSEG_W-1:0] n_eff;
	logic [HLEN_W-1:0] hdr_len;
	logic              drop_nxt;
	logic              force_hdr;
	logic              hdr_mode_eff;
	logic [CNT_W-1:0]  p;
	logic [HLEN_W-1:0] p_inc;
	logic [1:0]        lane;
	logic [1:0]        hseg;
	logic              hdr_end;
	logic [SEG_W-1:0]  idx;
	logic [BR_W-1:0]   br_inc;
	logic              seg_end;
	int                search_from;
	logic              found;
	logic [SEG_W-1:0]  found_idx;

	logic              hdr_mode_nxt;
	logic [CNT_W-1:0]  hdr_cnt_nxt;
	logic [TYPE_W-1:0] type_nxt;
	logic [WORD_W-1:0] len_nxt [MAX_SEGMENTS];
	logic [SEG_W-1:0]  cur_nxt;
	logic [BR_W-1:0]   br_nxt;
	logic [KIND_W-1:0] kind_nxt;
	logic [SIDX_W-1:0] sidx_nxt;
	logic [OFF_W-1:0]  off_nxt;
	logic              done_nxt;

	assign accept        = ingress.valid & ingress.ready;
	assign ingress.ready = ~res_valid_q | egress.ready;

	// effective segment count and header length
	always_comb begin
		n_eff = nseg_q;
		if (n_eff == '0) begin
			n_eff = NSEG_W'(1);
		end
		if (int'(n_eff) > MAX_SEGMENTS) begin
			n_eff = NSEG_W'(MAX_SEGMENTS);
		end
		hdr_len = {1'b0, n_eff, 2'b00} + HLEN_W'(4);
	end

	// packet start handling
	always_comb begin
		drop_nxt     = ingress.first_of_packet ? (ingress.packet_length < MIN_PACKET_LEN)
			: drop_q;
		force_hdr    = ingress.first_of_packet && !drop_nxt
			&& (ingress.packet_length == PLEN_W'(hdr_len));
		hdr_mode_eff = force_hdr | hdr_mode_q;
		p            = force_hdr ? '0 : hdr_cnt_q;
	end

	// header position decode and data position compare
	always_comb begin
		p_inc   = {1'b0, p} + HLEN_W'(1);
		lane    = p[1:0];
		hseg    = p[3:2] - 2'd1;
		hdr_end = p_inc >= hdr_len;
		idx     = ({1'b0, cur_q} >= (SEG_W + 1)'(n_eff)) ? '0 : cur_q;
		br_inc  = br_q + BR_W'(1);
		seg_end = br_inc >= {len_q[idx], 3'b000};
	end

	// header lane writes into type word and segment lengths
	always_comb begin
		type_nxt = type_q;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			len_nxt[i] = len_q[i];
		end
		if (!drop_nxt && hdr_mode_eff) begin
			if (p < CNT_W'(4)) begin
				if (lane == 2'd0) begin
					type_nxt = {{(TYPE_W - DATA_W){1'b0}}, ingress.data_byte};
				end else begin
					type_nxt[8*lane +: 8] = ingress.data_byte;
				end
			end else begin
				for (int i = 0; i < MAX_SEGMENTS; i++) begin
					if (int'(hseg) == i) begin
						if (lane == 2'd0) begin
							len_nxt[i] = {{(WORD_W - DATA_W){1'b0}}, ingress.data_byte};
						end else begin
							len_nxt[i][8*lane +: 8] = ingress.data_byte;
						end
					end
				end
			end
			if (hdr_end) begin
				for (int i = 0; i < MAX_SEGMENTS; i++) begin
					if (i >= int'(n_eff)) begin
						len_nxt[i] = '0;
					end
				end
			end
		end
	end

	// first non-empty segment at or after the search start
	always_comb begin
		search_from = hdr_mode_eff ? 0 : int'(idx) + 1;
		found       = 1'b0;
		found_idx   = '0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (i >= search_from && i < int'(n_eff) && len_nxt[i] != '0) begin
				found     = 1'b1;
				found_idx = SEG_W'(i);
			end
		end
	end

	// state advance and result fields
	always_comb begin
		hdr_mode_nxt = hdr_mode_q;
		hdr_cnt_nxt  = hdr_cnt_q;
		cur_nxt      = cur_q;
		br_nxt       = br_q;
		kind_nxt     = KIND_IGNORED;
		sidx_nxt     = '0;
		off_nxt      = '0;
		done_nxt     = 1'b0;
		if (!drop_nxt) begin
			hdr_mode_nxt = hdr_mode_eff;
			hdr_cnt_nxt  = p;
			if (hdr_mode_eff) begin
				kind_nxt = KIND_HEADER;
				if (hdr_end) begin
					hdr_cnt_nxt = '0;
					br_nxt      = '0;
					if (found) begin
						hdr_mode_nxt = 1'b0;
						cur_nxt      = found_idx;
					end else begin
						hdr_mode_nxt = 1'b1;
						cur_nxt      = '0;
						done_nxt     = 1'b1;
					end
				end else begin
					hdr_cnt_nxt = p_inc[CNT_W-1:0];
				end
			end else begin
				sidx_nxt = SIDX_W'(idx);
				if ((br_q >> SEGMENT_CAPACITY_LOG2) == '0) begin
					kind_nxt = KIND_DATA;
					off_nxt  = br_q[OFF_W-1:0];
				end else begin
					kind_nxt = KIND_OVERFLOW;
				end
				if (seg_end) begin
					br_nxt = '0;
					if (found) begin
						cur_nxt = found_idx;
					end else begin
						hdr_mode_nxt = 1'b1;
						hdr_cnt_nxt  = '0;
						cur_nxt      = '0;
						done_nxt     = 1'b1;
					end
				end else begin
					br_nxt  = br_inc;
					cur_nxt = idx;
				end
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nseg_q <= NSEG_RESET;
		end else if (cfg_wr_en) begin
			nseg_q <= cfg_wr_data;
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_mode_q <= 1'b1;
			hdr_cnt_q  <= '0;
			type_q     <= '0;
			cur_q      <= '0;
			br_q       <= '0;
			drop_q     <= 1'b0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				len_q[i] <= '0;
			end
		end else if (accept) begin
			hdr_mode_q <= hdr_mode_nxt;
			hdr_cnt_q  <= hdr_cnt_nxt;
			type_q     <= type_nxt;
			cur_q      <= cur_nxt;
			br_q       <= br_nxt;
			drop_q     <= drop_nxt;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				len_q[i] <= len_nxt[i];
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ingress.ready) begin
			res_valid_q <= ingress.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_kind_q <= kind_nxt;
			res_sidx_q <= sidx_nxt;
			res_off_q  <= off_nxt;
			res_data_q <= ingress.data_byte;
			res_done_q <= done_nxt;
			res_type_q <= type_nxt;
		end
	end

	assign egress.valid          = res_valid_q;
	assign egress.byte_kind      = res_kind_q;
	assign egress.segment_index  = res_sidx_q;
	assign egress.segment_offset = res_off_q;
	assign egress.data_out       = res_data_q;
	assign egress.message_done   = res_done_q;
	assign egress.message_type   = res_type_q;

	// a message never completes on an ignored byte
	assert property (@(posedge clk) disable iff (!arst_n)
		egress.valid && egress.message_done |-> egress.byte_kind != KIND_IGNORED)
		else $error("message done on ignored byte");

	// only in-capacity data bytes carry an offset
	assert property (@(posedge clk) disable iff (!arst_n)
		egress.valid && egress.byte_kind != KIND_DATA |-> egress.segment_offset == '0)
		else $error("offset on non-data byte");

	// a held result blocks ingress
	assert property (@(posedge clk) disable iff (!arst_n)
		egress.valid && !egress.ready |-> !ingress.ready)
		else $error("ingress open while result stalled");

endmodule
